// ----- hw/rtl/indexed_array_store_defines.svh -----
// Assertion macros for the checker file of the indexed array store
`ifndef INDEXED_ARRAY_STORE_DEFINES_SVH
`define INDEXED_ARRAY_STORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define IAS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: property failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define IAS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: property failed");

`endif

// ----- hw/rtl/ias_pkg.sv -----
// Types and constants shared by the indexed array store modules
package ias_pkg;

	localparam int OP_W   = 3;
	localparam int IDX_W  = 7;
	localparam int IDX2_W = 6;
	localparam int VAL_W  = 32;
	localparam int ST_W   = 2;
	localparam int RIDX_W = 6;
	localparam int CNT_W  = 7;
	localparam int WIDE_W = 64;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_INSERT = 3'd2,
		OP_REMOVE = 3'd3,
		OP_GET    = 3'd4,
		OP_SWAP   = 3'd5
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT,
		S_GET,
		S_SWAP_RD,
		S_SWAP_WA,
		S_SWAP_WB
	} state_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_ERR,
		ACT_PUSH,
		ACT_POP,
		ACT_SHIFT_INIT,
		ACT_SHIFT_STEP,
		ACT_SHIFT_END,
		ACT_RD_IDX,
		ACT_RD_IDX2,
		ACT_WR_IDX,
		ACT_WR_IDX2,
		ACT_GET
	} act_t;

	typedef struct packed {
		logic load;
		act_t act;
		logic respond;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic err;
		logic shift_done;
	} stat_t;

endpackage

// ----- hw/rtl/ias_ctrl.sv -----
// Controller state machine sequencing each transaction of the array store
module ias_ctrl import ias_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.err) begin
					state_d = S_IDLE;
				end else begin
					unique case (stat.op) inside
						OP_INSERT, OP_REMOVE: state_d = S_SHIFT;
						OP_GET:               state_d = S_GET;
						OP_SWAP:              state_d = S_SWAP_RD;
						default:              state_d = S_IDLE;
					endcase
				end
			end
			S_SHIFT: begin
				if (stat.shift_done) begin
					state_d = S_IDLE;
				end
			end
			S_GET:     state_d = S_IDLE;
			S_SWAP_RD: state_d = S_SWAP_WA;
			S_SWAP_WA: state_d = S_SWAP_WB;
			S_SWAP_WB: state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '{load: 1'b0, act: ACT_NONE, respond: 1'b0};
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_EXEC: begin
				if (stat.err) begin
					cmd.act     = ACT_ERR;
					cmd.respond = 1'b1;
				end else begin
					unique case (stat.op) inside
						OP_PUSH: begin
							cmd.act     = ACT_PUSH;
							cmd.respond = 1'b1;
						end
						OP_POP: begin
							cmd.act     = ACT_POP;
							cmd.respond = 1'b1;
						end
						OP_INSERT, OP_REMOVE: cmd.act = ACT_SHIFT_INIT;
						OP_GET, OP_SWAP:      cmd.act = ACT_RD_IDX;
						default:              cmd.respond = 1'b1;
					endcase
				end
			end
			S_SHIFT: begin
				if (stat.shift_done) begin
					cmd.act     = ACT_SHIFT_END;
					cmd.respond = 1'b1;
				end else begin
					cmd.act = ACT_SHIFT_STEP;
				end
			end
			S_GET: begin
				cmd.act     = ACT_GET;
				cmd.respond = 1'b1;
			end
			S_SWAP_RD: cmd.act = ACT_RD_IDX2;
			S_SWAP_WA: cmd.act = ACT_WR_IDX;
			S_SWAP_WB: begin
				cmd.act     = ACT_WR_IDX2;
				cmd.respond = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

endmodule

// ----- hw/rtl/ias_dpath.sv -----
// Datapath of the array store: element memory, count, shift cursor and result registers
module ias_dpath import ias_pkg::*; #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output stat_t                    stat,
	input  logic [OP_W-1:0]          op,
	input  logic [IDX_W-1:0]         index,
	input  logic [IDX2_W-1:0]        second_index,
	input  logic signed [VAL_W-1:0]  value,
	output logic                     done,
	output logic [ST_W-1:0]          status,
	output logic [RIDX_W-1:0]        result_index,
	output logic signed [VAL_W-1:0]  read_value,
	output logic [CNT_W-1:0]         count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int XW = (CW > IDX_W) ? CW : IDX_W;

	logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
	logic [DATA_WIDTH-1:0] rdat_q;
	logic [DATA_WIDTH-1:0] tmp_q;
	logic [DATA_WIDTH-1:0] val_q;
	op_t                   op_q;
	logic [XW-1:0]         idx_q;
	logic [IDX2_W-1:0]     idx2_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         ptr_q;
	logic                  pend_q;
	logic [AW-1:0]         paddr_q;
	status_t               status_q;
	logic [RIDX_W-1:0]     where_q;
	logic [VAL_W-1:0]      rdval_q;
	logic                  done_q;

	logic [XW-1:0]         cnt_x;
	logic [XW-1:0]         idx2_x;
	logic [CW-1:0]         idx_c;
	logic                  full;
	logic                  up;
	logic                  adv;
	status_t               chk_st;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic [AW-1:0]         raddr;
	logic [WIDE_W-1:0]     rd_ext;

	assign cnt_x  = XW'(cnt_q);
	assign idx2_x = XW'(idx2_q);
	assign idx_c  = CW'(idx_q);
	assign full   = (cnt_q == CW'(CAPACITY));
	assign up     = (op_q == OP_INSERT);
	assign adv    = up ? (ptr_q > idx_c)
	                   : (({1'b0, ptr_q} + (CW + 1)'(1)) < {1'b0, cnt_q});
	assign rd_ext = WIDE_W'(signed'(rdat_q));

	always_comb begin
		chk_st = ST_OK;
		unique case (op_q)
			OP_PUSH: begin
				if (full) begin
					chk_st = ST_FULL;
				end
			end
			OP_POP: begin
				if (cnt_q == '0) begin
					chk_st = ST_EMPTY;
				end
			end
			OP_INSERT: begin
				if (idx_q > cnt_x) begin
					chk_st = ST_BAD_INDEX;
				end else if (full) begin
					chk_st = ST_FULL;
				end
			end
			OP_REMOVE, OP_GET: begin
				if (idx_q >= cnt_x) begin
					chk_st = ST_BAD_INDEX;
				end
			end
			OP_SWAP: begin
				if ((idx_q >= cnt_x) || (idx2_x >= cnt_x)) begin
					chk_st = ST_BAD_INDEX;
				end
			end
			default: chk_st = ST_OK;
		endcase
	end

	assign stat.op         = op_q;
	assign stat.err        = (chk_st != ST_OK);
	assign stat.shift_done = !adv && !pend_q;

	always_comb begin
		we    = 1'b0;
		waddr = AW'(idx_q);
		wdata = rdat_q;
		raddr = AW'(idx_q);
		case (cmd.act)
			ACT_PUSH: begin
				we    = 1'b1;
				waddr = AW'(cnt_q);
				wdata = val_q;
			end
			ACT_SHIFT_STEP: begin
				we    = pend_q;
				waddr = paddr_q;
				wdata = rdat_q;
				raddr = up ? AW'(ptr_q - CW'(1)) : AW'(ptr_q + CW'(1));
			end
			ACT_SHIFT_END: begin
				we    = up;
				wdata = val_q;
			end
			ACT_RD_IDX2: raddr = AW'(idx2_q);
			ACT_WR_IDX:  we = 1'b1;
			ACT_WR_IDX2: begin
				we    = 1'b1;
				waddr = AW'(idx2_q);
				wdata = tmp_q;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdat_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.respond;
			case (cmd.act)
				ACT_PUSH:       cnt_q  <= cnt_q + CW'(1);
				ACT_POP:        cnt_q  <= cnt_q - CW'(1);
				ACT_SHIFT_INIT: pend_q <= 1'b0;
				ACT_SHIFT_STEP: pend_q <= adv;
				ACT_SHIFT_END:  cnt_q  <= up ? cnt_q + CW'(1) : cnt_q - CW'(1);
				default:        pend_q <= pend_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(op);
			idx_q    <= XW'(index);
			idx2_q   <= second_index;
			val_q    <= DATA_WIDTH'($unsigned(value));
			status_q <= ST_OK;
			where_q  <= '0;
			rdval_q  <= '0;
		end
		case (cmd.act)
			ACT_ERR:  status_q <= chk_st;
			ACT_PUSH: where_q  <= RIDX_W'(cnt_q);
			ACT_POP:  where_q  <= RIDX_W'(cnt_q - CW'(1));
			ACT_SHIFT_INIT: begin
				ptr_q <= up ? cnt_q : idx_c;
			end
			ACT_SHIFT_STEP: begin
				if (adv) begin
					paddr_q <= AW'(ptr_q);
					ptr_q   <= up ? ptr_q - CW'(1) : ptr_q + CW'(1);
				end
			end
			ACT_SHIFT_END: where_q <= RIDX_W'(idx_q);
			ACT_RD_IDX2:   tmp_q   <= rdat_q;
			ACT_WR_IDX:    where_q <= RIDX_W'(idx_q);
			ACT_GET: begin
				rdval_q <= rd_ext[VAL_W-1:0];
				where_q <= RIDX_W'(idx_q);
			end
			default: ;
		endcase
	end

	assign done         = done_q;
	assign status       = status_q;
	assign result_index = where_q;
	assign read_value   = signed'(rdval_q);
	assign count        = CNT_W'(cnt_q);

endmodule

// ----- hw/rtl/indexed_array_store.sv -----
// Sequence from acceptance to done: push, pop, errors and unused ops respond from the execute state;
// get adds a registered read, swap reads both elements and writes each back, and insert or remove
// steps the element shift through the memory one element at a time before it responds.
// One transaction at a time; done marks a result for one cycle, busy is low then, so start may follow.
// Reset clears the element count and the controller; memory contents stay undefined until written.
// Top level of the indexed array store
module indexed_array_store import ias_pkg::*; #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [OP_W-1:0]          op,
	input  logic [IDX_W-1:0]         index,
	input  logic [IDX2_W-1:0]        second_index,
	input  logic signed [VAL_W-1:0]  value,
	output logic                     done,
	output logic [ST_W-1:0]          status,
	output logic [RIDX_W-1:0]        result_index,
	output logic signed [VAL_W-1:0]  read_value,
	output logic [CNT_W-1:0]         count
);

	cmd_t  cmd;
	stat_t stat;

	ias_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	ias_dpath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (op),
		.index        (index),
		.second_index (second_index),
		.value        (value),
		.done         (done),
		.status       (status),
		.result_index (result_index),
		.read_value   (read_value),
		.count        (count)
	);

endmodule

// ----- hw/rtl/ias_chk.sv -----
// Port-level checker for the indexed array store, bound to the top level
`include "indexed_array_store_defines.svh"

module ias_chk import ias_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic [OP_W-1:0]          op,
	input logic [IDX_W-1:0]         index,
	input logic [IDX2_W-1:0]        second_index,
	input logic signed [VAL_W-1:0]  value,
	input logic                     done,
	input logic [ST_W-1:0]          status,
	input logic [RIDX_W-1:0]        result_index,
	input logic signed [VAL_W-1:0]  read_value,
	input logic [CNT_W-1:0]         count
);

	`IAS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
	`IAS_ASSERT_SAME(a_done_idle, done, !busy && $past(busy))
	`IAS_ASSERT_SAME(a_release_done, $fell(busy), done)
	`IAS_ASSERT_SAME(a_err_no_data, done && (status != ST_OK), read_value == '0 && result_index == '0)
	`IAS_ASSERT_SAME(a_empty_count, done && (status == ST_EMPTY), count == '0)

endmodule

bind indexed_array_store ias_chk u_ias_chk (.*);

// ----- dv/tb_indexed_array_store.sv -----
// Self-checking testbench for the indexed array store: directed edge cases, then random traffic
module tb_indexed_array_store;
	timeunit 1ns;
	timeprecision 1ps;

	import ias_pkg::*;

	localparam int CAP = 64;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		status_t           st;
		logic [RIDX_W-1:0] where_idx;
		logic [VAL_W-1:0]  rd;
		logic [CNT_W-1:0]  cnt;
	} outcome_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [OP_W-1:0]         op;
	logic [IDX_W-1:0]        index;
	logic [IDX2_W-1:0]       second_index;
	logic signed [VAL_W-1:0] value;
	logic                    done;
	logic [ST_W-1:0]         status;
	logic [RIDX_W-1:0]       result_index;
	logic signed [VAL_W-1:0] read_value;
	logic [CNT_W-1:0]        count;

	logic [VAL_W-1:0] store_elems [CAP];
	int               store_count;
	outcome_t         pending_results [$];
	int               fail_count;
	int               stall_cycles;
	bit               no_gaps;

	indexed_array_store #(.CAPACITY(CAP), .DATA_WIDTH(VAL_W)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op), .index(index),
		.second_index(second_index), .value(value), .done(done), .status(status),
		.result_index(result_index), .read_value(read_value), .count(count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic outcome_t predict_store_op(input logic [OP_W-1:0] o,
			input logic [IDX_W-1:0] idx, input logic [IDX2_W-1:0] idx2,
			input logic [VAL_W-1:0] v);
		outcome_t         r;
		int               k;
		logic [VAL_W-1:0] t;
		r.st = ST_OK;
		r.where_idx = '0;
		r.rd = '0;
		case (o)
			OP_PUSH: begin
				if (store_count >= CAP) begin
					r.st = ST_FULL;
				end else begin
					store_elems[store_count] = v;
					r.where_idx = RIDX_W'(store_count);
					store_count++;
				end
			end
			OP_POP: begin
				if (store_count == 0) begin
					r.st = ST_EMPTY;
				end else begin
					store_count--;
					r.where_idx = RIDX_W'(store_count);
				end
			end
			OP_INSERT: begin
				if (int'(idx) > store_count) begin
					r.st = ST_BAD_INDEX;
				end else if (store_count >= CAP) begin
					r.st = ST_FULL;
				end else begin
					for (k = store_count; k > int'(idx); k--)
						store_elems[k] = store_elems[k-1];
					store_elems[idx] = v;
					store_count++;
					r.where_idx = RIDX_W'(idx);
				end
			end
			OP_REMOVE: begin
				if (int'(idx) >= store_count) begin
					r.st = ST_BAD_INDEX;
				end else begin
					for (k = idx; k + 1 < store_count; k++)
						store_elems[k] = store_elems[k+1];
					store_count--;
					r.where_idx = RIDX_W'(idx);
				end
			end
			OP_GET: begin
				if (int'(idx) >= store_count) begin
					r.st = ST_BAD_INDEX;
				end else begin
					r.rd = store_elems[idx];
					r.where_idx = RIDX_W'(idx);
				end
			end
			OP_SWAP: begin
				if (int'(idx) >= store_count || int'(idx2) >= store_count) begin
					r.st = ST_BAD_INDEX;
				end else begin
					t = store_elems[idx];
					store_elems[idx] = store_elems[idx2];
					store_elems[idx2] = t;
					r.where_idx = RIDX_W'(idx);
				end
			end
			default: ;
		endcase
		r.cnt = CNT_W'(store_count);
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] pick_index(input bit allow_end);
		if ($urandom_range(0, 9) == 0)
			return IDX_W'($urandom_range(0, CAP));
		if (allow_end)
			return IDX_W'($urandom_range(0, store_count));
		if (store_count == 0)
			return IDX_W'($urandom_range(0, CAP));
		return IDX_W'($urandom_range(0, store_count - 1));
	endfunction

	function automatic logic [IDX2_W-1:0] pick_second_index();
		if (store_count == 0 || $urandom_range(0, 9) == 0)
			return IDX2_W'($urandom_range(0, CAP - 1));
		return IDX2_W'($urandom_range(0, store_count - 1));
	endfunction

	task automatic pause_after();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50)
			n = 0;
		else if (r < 90)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(10, 40);
		if (n > 0) begin
			@(negedge clk);
			start = 1'b0;
			op = OP_W'($urandom);
			index = IDX_W'($urandom);
			second_index = IDX2_W'($urandom);
			value = $urandom;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic send_op(input logic [OP_W-1:0] o, input logic [IDX_W-1:0] idx,
			input logic [IDX2_W-1:0] idx2, input logic [VAL_W-1:0] v);
		@(negedge clk);
		start = 1'b1;
		op = o;
		index = idx;
		second_index = idx2;
		value = v;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_store_op(o, idx, idx2, v));
		pause_after();
	endtask

	task automatic test_directed_edges();
		send_op(OP_POP, 0, 0, $urandom);
		send_op(OP_GET, 0, 0, $urandom);
		send_op(OP_REMOVE, 0, 0, $urandom);
		send_op(OP_SWAP, 0, 0, $urandom);
		send_op(OP_INSERT, 1, 0, $urandom);
		send_op(3'd6, IDX_W'($urandom_range(0, CAP)), IDX2_W'($urandom), $urandom);
		send_op(3'd7, IDX_W'($urandom_range(0, CAP)), IDX2_W'($urandom), $urandom);
		send_op(OP_INSERT, 0, 0, 32'h8000_0000);
		send_op(OP_PUSH, 0, 0, 32'h7fff_ffff);
		send_op(OP_PUSH, 0, 0, 32'h0000_0000);
		send_op(OP_PUSH, 0, 0, 32'hffff_ffff);
		send_op(OP_INSERT, IDX_W'(CAP), 0, 32'h1234_5678);
		send_op(OP_INSERT, 4, 0, 32'h5555_5555);
		send_op(OP_INSERT, 2, 0, 32'haaaa_aaaa);
		send_op(OP_GET, 0, 0, $urandom);
		send_op(OP_GET, 5, 0, $urandom);
		send_op(OP_GET, 6, 0, $urandom);
		send_op(OP_SWAP, 0, 5, $urandom);
		send_op(OP_SWAP, 1, IDX2_W'(CAP - 1), $urandom);
		send_op(OP_GET, IDX_W'(CAP), IDX2_W'(CAP - 1), $urandom);
		send_op(OP_REMOVE, 0, 0, $urandom);
		send_op(OP_REMOVE, 4, 0, $urandom);
		send_op(OP_POP, 0, 0, $urandom);
		send_op(OP_GET, 1, 0, $urandom);
	endtask

	task automatic test_random_traffic(input int n_items);
		bit               growing;
		int               linger;
		int               w;
		logic [OP_W-1:0]  o;
		growing = 1'b1;
		linger = 0;
		for (int i = 0; i < n_items; i++) begin
			if (i % 100 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			if (growing && store_count == CAP && linger == 0)
				linger = $urandom_range(3, 8);
			if (!growing && store_count == 0 && linger == 0)
				linger = $urandom_range(2, 5);
			if (linger > 0) begin
				linger--;
				if (linger == 0)
					growing = !growing;
			end
			w = $urandom_range(0, 99);
			if (w < 2)
				o = OP_W'($urandom_range(6, 7));
			else if (w < 12)
				o = OP_GET;
			else if (w < 20)
				o = OP_SWAP;
			else if (w < 30)
				o = growing ? OP_POP : OP_PUSH;
			else if (w < 40)
				o = growing ? OP_REMOVE : OP_INSERT;
			else if (w < 70)
				o = growing ? OP_PUSH : OP_POP;
			else
				o = growing ? OP_INSERT : OP_REMOVE;
			send_op(o, pick_index(o == OP_INSERT), pick_second_index(), pick_value());
		end
	endtask

	always @(posedge clk) begin : check_results
		outcome_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing pending: status %0d index %0d count %0d",
					$time, status, result_index, count);
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					fail_count++;
				end
				if (result_index !== e.where_idx) begin
					$display("%0t: result_index expected %0d actual %0d",
						$time, e.where_idx, result_index);
					fail_count++;
				end
				if (read_value !== e.rd) begin
					$display("%0t: read_value expected %h actual %h", $time, e.rd, read_value);
					fail_count++;
				end
				if (count !== e.cnt) begin
					$display("%0t: count expected %0d actual %0d", $time, e.cnt, count);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_indexed_array_store: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		op = '0;
		index = '0;
		second_index = '0;
		value = '0;
		store_count = 0;
		fail_count = 0;
		stall_cycles = 0;
		no_gaps = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_edges();
		test_random_traffic(1100);

		// drop start and drain outstanding transactions
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (CAP + 8) @(posedge clk);

		if (fail_count == 0)
			$display("tb_indexed_array_store: done, clean");
		else
			$display("tb_indexed_array_store: done, errors");
		$finish;
	end

endmodule
